### design/urxts_pkg.sv
// Package for the edge-timestamp UART receiver: constants, microcode
// encodings, the control store and the bit-fill helper.
// No dependencies.
package urxts_pkg;

    // Frame and timing constants
    localparam int TIME_BITS_DEF = 32;
    localparam int PERIOD_W      = 24;
    localparam int BYTE_W        = 8;
    localparam int BITS_W        = 4;
    localparam int LIMIT_W       = BITS_W + PERIOD_W;
    localparam int FRAME_BITS    = 9;
    localparam int TIMEOUT_BITS  = 10;
    localparam int BITS_SAT      = 15;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd868;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_DELTA,
        OP_DIV,
        OP_ROUND,
        OP_EDGE,
        OP_IDLE_EDGE,
        OP_LIMIT,
        OP_TOUT,
        OP_EMIT
    } op_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_POLL,
        C_IDLE,
        C_NOT_OPEN,
        C_DIV_MORE,
        C_NO_RESULT,
        C_OUT_FULL
    } cond_t;

    // Control store addresses
    typedef enum logic [3:0] {
        S_FETCH,
        S_DELTA,
        S_CHK_IDLE,
        S_DIV,
        S_ROUND,
        S_EDGE,
        S_EMIT,
        S_IDLE_EDGE,
        S_LIMIT,
        S_TOUT
    } step_t;

    // One control word: operation, jump when cond holds, else go to nxt
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jmp;
        step_t nxt;
    } uword_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic no_input;
        logic poll;
        logic idle;
        logic not_open;
        logic div_more;
        logic no_result;
        logic out_full;
    } status_t;

    // Microprogram
    function automatic uword_t ucode(input step_t step);
        uword_t w;
        begin
            w = '{op: OP_NOP, cond: C_ALWAYS, jmp: S_FETCH, nxt: S_FETCH};
            unique case (step)
                S_FETCH:     w = '{op: OP_FETCH,     cond: C_NO_INPUT,  jmp: S_FETCH,
                                   nxt: S_DELTA};
                S_DELTA:     w = '{op: OP_DELTA,     cond: C_POLL,      jmp: S_LIMIT,
                                   nxt: S_CHK_IDLE};
                S_CHK_IDLE:  w = '{op: OP_NOP,       cond: C_IDLE,      jmp: S_IDLE_EDGE,
                                   nxt: S_DIV};
                S_DIV:       w = '{op: OP_DIV,       cond: C_DIV_MORE,  jmp: S_DIV,
                                   nxt: S_ROUND};
                S_ROUND:     w = '{op: OP_ROUND,     cond: C_NEVER,     jmp: S_FETCH,
                                   nxt: S_EDGE};
                S_EDGE:      w = '{op: OP_EDGE,      cond: C_NO_RESULT, jmp: S_FETCH,
                                   nxt: S_EMIT};
                S_EMIT:      w = '{op: OP_EMIT,      cond: C_OUT_FULL,  jmp: S_EMIT,
                                   nxt: S_FETCH};
                S_IDLE_EDGE: w = '{op: OP_IDLE_EDGE, cond: C_ALWAYS,    jmp: S_FETCH,
                                   nxt: S_FETCH};
                S_LIMIT:     w = '{op: OP_LIMIT,     cond: C_NOT_OPEN,  jmp: S_FETCH,
                                   nxt: S_TOUT};
                S_TOUT:      w = '{op: OP_TOUT,      cond: C_NO_RESULT, jmp: S_FETCH,
                                   nxt: S_EMIT};
                default:     w = '{op: OP_NOP,       cond: C_ALWAYS,    jmp: S_FETCH,
                                   nxt: S_FETCH};
            endcase
            return w;
        end
    endfunction

    // Shift n copies of level (n in 0..8) into the top of a byte
    function automatic logic [BYTE_W-1:0] shift_in(input logic [BYTE_W-1:0] data,
                                                   input logic [BITS_W-1:0] n,
                                                   input logic level);
        logic [2*BYTE_W-1:0] mask;
        logic [BYTE_W-1:0]   fill;
        begin
            mask = 16'hFF00 >> n;
            fill = level ? mask[BYTE_W-1:0] : '0;
            return fill | (data >> n);
        end
    endfunction

endpackage

### design/urxts_seq.sv
// Microcode sequencer: step counter, control store lookup, conditional jumps.
// Depends on urxts_pkg.
module urxts_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  urxts_pkg::status_t status,
    output urxts_pkg::op_t     op
);

    urxts_pkg::step_t  pc_reg, pc_next;
    urxts_pkg::uword_t word;
    logic              cond_true;

    // Control word output
    always_comb begin
        word = urxts_pkg::ucode(pc_reg);
        op   = word.op;
    end

    // Condition select and next step
    always_comb begin
        unique case (word.cond)
            urxts_pkg::C_NEVER:     cond_true = 1'b0;
            urxts_pkg::C_ALWAYS:    cond_true = 1'b1;
            urxts_pkg::C_NO_INPUT:  cond_true = status.no_input;
            urxts_pkg::C_POLL:      cond_true = status.poll;
            urxts_pkg::C_IDLE:      cond_true = status.idle;
            urxts_pkg::C_NOT_OPEN:  cond_true = status.not_open;
            urxts_pkg::C_DIV_MORE:  cond_true = status.div_more;
            urxts_pkg::C_NO_RESULT: cond_true = status.no_result;
            urxts_pkg::C_OUT_FULL:  cond_true = status.out_full;
            default:                cond_true = 1'b1;
        endcase
        pc_next = cond_true ? word.jmp : word.nxt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= urxts_pkg::S_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // An accepted transaction always starts the delta step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == urxts_pkg::S_FETCH && !status.no_input) |=> pc_reg == urxts_pkg::S_DELTA)
        else $error("accepted transaction did not start delta step");

endmodule

### design/urxts_dp.sv
// Datapath: input latch, interval subtract, shift-subtract divider, bit
// fill logic, timeout test and output register. Depends on urxts_pkg.
module urxts_dp #(
    parameter int TIME_BITS = urxts_pkg::TIME_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  urxts_pkg::op_t                  op,
    output urxts_pkg::status_t              status,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [TIME_BITS-1:0]            s_timestamp,
    input  logic                            s_line_level,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [urxts_pkg::BYTE_W-1:0]    m_rx_byte,
    output logic                            m_by_timeout,
    input  logic                            cfg_wr_en,
    input  logic [urxts_pkg::PERIOD_W-1:0]  cfg_wr_data
);

    localparam int CNT_W = $clog2(TIME_BITS + 1);
    localparam int CMP_W = (TIME_BITS > urxts_pkg::LIMIT_W) ? TIME_BITS : urxts_pkg::LIMIT_W;
    localparam int PW    = urxts_pkg::PERIOD_W;
    localparam int BW    = urxts_pkg::BITS_W;
    localparam int YW    = urxts_pkg::BYTE_W;

    // Control state
    logic [PW-1:0]        period_reg, period_next;
    logic [BW-1:0]        bt_reg, bt_next;
    logic [YW-1:0]        shift_reg, shift_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic                 m_valid_reg, m_valid_next;

    // Payload
    logic                 kind_reg, kind_next;
    logic                 level_reg, level_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] delta_reg, delta_next;
    logic [TIME_BITS-1:0] quo_reg, quo_next;
    logic [PW-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [BW-1:0]        bits_reg, bits_next;
    logic [urxts_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic [YW-1:0]        res_byte_reg, res_byte_next;
    logic                 res_tout_reg, res_tout_next;
    logic [YW-1:0]        m_byte_reg, m_byte_next;
    logic                 m_tout_reg, m_tout_next;

    // Combinational helpers
    logic [PW-1:0]        bl;
    logic [PW:0]          trial, trial_sub;
    logic                 trial_ge;
    logic                 rnd;
    logic                 q_big;
    logic [BW-1:0]        pad0, room, pad, bt1, b1, bt2, b2;
    logic [YW-1:0]        sh1, sh2;
    logic                 edge_emit;
    logic [BW-1:0]        missed;
    logic [YW-1:0]        tout_byte;
    logic                 tout_hit;
    logic                 open_frame;
    logic                 res_now;
    logic                 out_full;

    // Divisor: a zero period acts as one
    assign bl = (period_reg == '0) ? PW'(1) : period_reg;

    // One restoring divide step
    always_comb begin
        trial     = {rem_reg, quo_reg[TIME_BITS-1]};
        trial_sub = trial - {1'b0, bl};
        trial_ge  = trial >= {1'b0, bl};
    end

    // Rounding and saturation of the bit count
    assign rnd   = rem_reg >= (bl - (bl >> 1));
    assign q_big = quo_reg >= TIME_BITS'(urxts_pkg::BITS_SAT);

    // Bit fill for an edge inside an open frame
    always_comb begin
        pad0 = (bits_reg > BW'(1)) ? bits_reg - BW'(1) : '0;
        room = (bt_reg < BW'(urxts_pkg::FRAME_BITS)) ?
               BW'(urxts_pkg::FRAME_BITS) - bt_reg : '0;
        pad  = (pad0 > room) ? room : pad0;
        sh1  = urxts_pkg::shift_in(shift_reg, pad, ~level_reg);
        bt1  = bt_reg + pad;
        b1   = bits_reg - pad;
        if (bt1 < BW'(urxts_pkg::FRAME_BITS) && b1 != '0) begin
            sh2 = urxts_pkg::shift_in(sh1, BW'(1), level_reg);
            bt2 = bt1 + BW'(1);
            b2  = b1 - BW'(1);
        end else begin
            sh2 = sh1;
            bt2 = bt1;
            b2  = b1;
        end
        edge_emit = bt2 >= BW'(urxts_pkg::FRAME_BITS);
    end

    // Timeout test and fill
    always_comb begin
        open_frame = (bt_reg != '0) && (bt_reg < BW'(urxts_pkg::TIMEOUT_BITS));
        missed     = (bt_reg < BW'(urxts_pkg::FRAME_BITS)) ?
                     BW'(urxts_pkg::FRAME_BITS) - bt_reg : '0;
        tout_byte  = urxts_pkg::shift_in(shift_reg, missed, shift_reg[YW-1]);
        tout_hit   = open_frame && (CMP_W'(delta_reg) > CMP_W'(limit_reg));
    end

    // Status to the sequencer
    always_comb begin
        out_full = m_valid_reg && !m_ready;
        unique case (op)
            urxts_pkg::OP_EDGE: res_now = edge_emit;
            urxts_pkg::OP_TOUT: res_now = tout_hit;
            default:            res_now = 1'b0;
        endcase
        status.no_input  = !s_valid;
        status.poll      = kind_reg;
        status.idle      = (bt_reg == '0);
        status.not_open  = !open_frame;
        status.div_more  = (cnt_reg != CNT_W'(1));
        status.no_result = !res_now;
        status.out_full  = out_full;
    end

    assign s_ready      = (op == urxts_pkg::OP_FETCH);
    assign m_valid      = m_valid_reg;
    assign m_rx_byte    = m_byte_reg;
    assign m_by_timeout = m_tout_reg;

    // Next-value logic
    always_comb begin
        period_next   = cfg_wr_en ? cfg_wr_data : period_reg;
        bt_next       = bt_reg;
        shift_next    = shift_reg;
        last_next     = last_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        kind_next     = kind_reg;
        level_next    = level_reg;
        now_next      = now_reg;
        delta_next    = delta_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        bits_next     = bits_reg;
        limit_next    = limit_reg;
        res_byte_next = res_byte_reg;
        res_tout_next = res_tout_reg;
        m_byte_next   = m_byte_reg;
        m_tout_next   = m_tout_reg;

        unique case (op)
            urxts_pkg::OP_FETCH: begin
                if (s_valid) begin
                    kind_next  = s_kind;
                    level_next = s_line_level;
                    now_next   = s_timestamp;
                end
            end
            urxts_pkg::OP_DELTA: begin
                delta_next = now_reg - last_reg;
                quo_next   = now_reg - last_reg;
                rem_next   = '0;
                cnt_next   = CNT_W'(TIME_BITS);
            end
            urxts_pkg::OP_DIV: begin
                rem_next = trial_ge ? trial_sub[PW-1:0] : trial[PW-1:0];
                quo_next = {quo_reg[TIME_BITS-2:0], trial_ge};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            urxts_pkg::OP_ROUND: begin
                bits_next = q_big ? BW'(urxts_pkg::BITS_SAT) : quo_reg[BW-1:0] + BW'(rnd);
            end
            urxts_pkg::OP_EDGE: begin
                last_next  = now_reg;
                shift_next = sh2;
                bt_next    = bt2;
                if (edge_emit) begin
                    res_byte_next = sh2;
                    res_tout_next = 1'b0;
                    shift_next    = '0;
                    bt_next       = '0;
                end
                if (b2 != '0 && !level_reg) begin
                    bt_next = BW'(1);
                end
            end
            urxts_pkg::OP_IDLE_EDGE: begin
                last_next = now_reg;
                if (!level_reg) begin
                    bt_next = BW'(1);
                end
            end
            urxts_pkg::OP_LIMIT: begin
                limit_next = (BW'(urxts_pkg::TIMEOUT_BITS) - bt_reg) * bl;
            end
            urxts_pkg::OP_TOUT: begin
                if (tout_hit) begin
                    res_byte_next = tout_byte;
                    res_tout_next = 1'b1;
                    shift_next    = '0;
                    bt_next       = '0;
                end
            end
            urxts_pkg::OP_EMIT: begin
                if (!out_full) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = res_byte_reg;
                    m_tout_next  = res_tout_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= urxts_pkg::PERIOD_RESET;
            bt_reg      <= '0;
            shift_reg   <= '0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            period_reg  <= period_next;
            bt_reg      <= bt_next;
            shift_reg   <= shift_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        level_reg    <= level_next;
        now_reg      <= now_next;
        delta_reg    <= delta_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        bits_reg     <= bits_next;
        limit_reg    <= limit_next;
        res_byte_reg <= res_byte_next;
        res_tout_reg <= res_tout_next;
        m_byte_reg   <= m_byte_next;
        m_tout_reg   <= m_tout_next;
    end

    // Between transactions a frame never holds a full byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (op == urxts_pkg::OP_FETCH) |-> (bt_reg < BW'(urxts_pkg::FRAME_BITS)))
        else $error("frame bit count out of range while waiting");

    // An idle receiver holds a cleared shift byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (op == urxts_pkg::OP_FETCH && bt_reg == '0) |-> (shift_reg == '0))
        else $error("shift byte not cleared while idle");

    // Divider remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (op == urxts_pkg::OP_DIV) |-> (rem_reg < bl))
        else $error("divider remainder not below divisor");

endmodule

### design/uart_rx_edge_timestamp_decoder.sv
// UART 8N1 receiver fed by line-edge timestamps. Each transaction is either
// an edge (timestamp plus new line level) or a poll tick (timestamp only);
// a received byte comes out LSB first with a flag telling whether a poll
// timeout completed it. bit_period is written through cfg_wr_en/cfg_wr_data
// (reset 868 ticks, zero acts as one) and must only be changed while idle.
// A microcoded sequencer drives one shared datapath and one transaction is
// handled at a time. After fetch and delta, an edge in an open frame runs
// the divide, round and edge steps, plus emit if it completes a byte; the
// one-bit-per-cycle shift-subtract divider turns the edge interval into bit
// times. An idle edge runs idle-edge, a poll tick runs limit and, in an open
// frame, timeout. A result waits in an output register and the next
// transaction is accepted meanwhile; only a second result blocks until the
// first is taken. Depends on urxts_pkg, urxts_seq and urxts_dp.
module uart_rx_edge_timestamp_decoder #(
    parameter int TIME_BITS = urxts_pkg::TIME_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [TIME_BITS-1:0]            s_timestamp,
    input  logic                            s_line_level,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [urxts_pkg::BYTE_W-1:0]    m_rx_byte,
    output logic                            m_by_timeout,
    input  logic                            cfg_wr_en,
    input  logic [urxts_pkg::PERIOD_W-1:0]  cfg_wr_data
);

    urxts_pkg::op_t     op;
    urxts_pkg::status_t status;

    // Step counter and control store
    urxts_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .op      (op)
    );

    // Datapath under microcode control
    urxts_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (op),
        .status       (status),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_timestamp  (s_timestamp),
        .s_line_level (s_line_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_rx_byte    (m_rx_byte),
        .m_by_timeout (m_by_timeout),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Testbench for uart_rx_edge_timestamp_decoder: builds UART frames as edge and poll
// transactions, predicts received bytes in-bench and checks them. Needs urxts_pkg and the DUT.
module tb;

    localparam int          TW              = urxts_pkg::TIME_BITS_DEF;
    localparam logic        KIND_EDGE       = 1'b0;
    localparam logic        KIND_POLL       = 1'b1;
    localparam int          PHASE_ITEMS     = 200;
    localparam int          SETTLE_CYCLES   = 60;
    localparam int          RX_STALL_CYCLES = 400;
    localparam int          CYCLE_LIMIT     = 2000000;
    localparam logic [31:0] DIR_PERIOD      = 32'd868;

    typedef struct packed {
        logic          kind;
        logic [TW-1:0] ts;
        logic          level;
    } line_event_t;

    typedef struct packed {
        logic [urxts_pkg::BYTE_W-1:0] data;
        logic                         by_tout;
    } rx_result_t;

    logic                           aclk;
    logic                           aresetn      = 1'b0;
    logic                           s_valid      = 1'b0;
    logic                           s_ready;
    logic                           s_kind       = 1'b0;
    logic [TW-1:0]                  s_timestamp  = '0;
    logic                           s_line_level = 1'b1;
    logic                           m_valid;
    logic                           m_ready      = 1'b0;
    logic [urxts_pkg::BYTE_W-1:0]   m_rx_byte;
    logic                           m_by_timeout;
    logic                           cfg_wr_en    = 1'b0;
    logic [urxts_pkg::PERIOD_W-1:0] cfg_wr_data  = urxts_pkg::PERIOD_RESET;

    // Stimulus and scoreboard storage
    line_event_t pending_events[$];
    rx_result_t  bytes_due[$];
    line_event_t drv_item;
    rx_result_t  got_byte;
    int          events_queued = 0;
    int          send_gap      = 0;
    int          rx_hold       = 0;
    int          bytes_seen    = 0;
    int          errors        = 0;
    int          cycle_count   = 0;
    bit          no_idle       = 1'b0;

    // Decoder state mirror
    logic [urxts_pkg::BITS_W-1:0]   rx_bits;
    logic [urxts_pkg::BYTE_W-1:0]   rx_shift;
    logic [TW-1:0]                  edge_stamp;
    logic [urxts_pkg::PERIOD_W-1:0] period_cfg;

    uart_rx_edge_timestamp_decoder DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_timestamp  (s_timestamp),
        .s_line_level (s_line_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_rx_byte    (m_rx_byte),
        .m_by_timeout (m_by_timeout),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Push n copies of level in at bit 7, older bits move toward bit 0
    function automatic logic [urxts_pkg::BYTE_W-1:0] fill_top(
        input logic [urxts_pkg::BYTE_W-1:0] d, input int n, input logic level);
        for (int i = 0; i < n; i++) d = {level, d[urxts_pkg::BYTE_W-1:1]};
        return d;
    endfunction

    // Advance the decoder mirror by one transaction; queue the byte it completes
    task automatic predict_rx(input line_event_t ev);
        logic [63:0] bl, delta, q, r, nbits, pad, room, passed, lim;
        bl = (period_cfg == '0) ? 64'd1 : {40'b0, period_cfg};
        if (ev.kind == KIND_EDGE) begin
            if (rx_bits == 0) begin
                if (!ev.level) rx_bits = 4'd1;
            end else begin
                delta = {32'b0, ev.ts - edge_stamp};
                q     = delta / bl;
                r     = delta % bl;
                nbits = q + (((r + bl / 2) >= bl) ? 64'd1 : 64'd0);
                if (nbits > 1) begin
                    pad  = nbits - 1;
                    room = (rx_bits < urxts_pkg::FRAME_BITS) ?
                           64'(urxts_pkg::FRAME_BITS) - 64'(rx_bits) : 64'd0;
                    if (pad > room) pad = room;
                    rx_shift = fill_top(rx_shift, int'(pad), ~ev.level);
                    rx_bits  = rx_bits + pad[urxts_pkg::BITS_W-1:0];
                    nbits    = nbits - pad;
                end
                if (rx_bits < urxts_pkg::FRAME_BITS && nbits != 0) begin
                    rx_shift = fill_top(rx_shift, 1, ev.level);
                    rx_bits  = rx_bits + 4'd1;
                    nbits    = nbits - 1;
                end
                if (rx_bits >= urxts_pkg::FRAME_BITS) begin
                    bytes_due.push_back('{data: rx_shift, by_tout: 1'b0});
                    rx_shift = '0;
                    rx_bits  = '0;
                end
                if (nbits != 0 && !ev.level) rx_bits = 4'd1;
            end
            edge_stamp = ev.ts;
        end else if (rx_bits > 0 && rx_bits < urxts_pkg::TIMEOUT_BITS) begin
            passed = {32'b0, ev.ts - edge_stamp};
            lim    = (64'(urxts_pkg::TIMEOUT_BITS) - 64'(rx_bits)) * bl;
            if (passed > lim) begin
                rx_shift = fill_top(rx_shift,
                                    (rx_bits < urxts_pkg::FRAME_BITS) ?
                                    urxts_pkg::FRAME_BITS - int'(rx_bits) : 0,
                                    rx_shift[urxts_pkg::BYTE_W-1]);
                bytes_due.push_back('{data: rx_shift, by_tout: 1'b1});
                rx_shift = '0;
                rx_bits  = '0;
            end
        end
    endtask

    task automatic queue_event(input logic kind, input logic [TW-1:0] ts, input logic level);
        pending_events.push_back('{kind: kind, ts: ts, level: level});
        events_queued++;
    endtask

    // One 8N1 frame starting at t0: an edge wherever the line changes, over the
    // first n_bits bit slots (10 = through the stop bit)
    task automatic queue_frame(input logic [7:0] data, input logic [31:0] t0,
                               input logic [31:0] per, input int jit, input bit skip_start,
                               input int n_bits);
        logic        lvl, prev;
        logic [31:0] ts;
        prev = 1'b1;
        for (int i = 0; i < n_bits; i++) begin
            lvl = (i == 0) ? 1'b0 : (i == 9) ? 1'b1 : data[i-1];
            if (lvl != prev) begin
                ts = t0 + per * i;
                if (i != 0 && jit > 0) ts = ts + $urandom_range(0, 2 * jit) - jit;
                if (!(i == 0 && skip_start)) queue_event(KIND_EDGE, ts, lvl);
            end
            prev = lvl;
        end
    endtask

    // Directed opening at the reset bit period
    task automatic queue_directed();
        logic [31:0] t, p;
        p = DIR_PERIOD;
        // poll while idle, then a rising edge while idle
        queue_event(KIND_POLL, 32'h0000_0000, 1'b1);
        queue_event(KIND_EDGE, 32'hFFFF_FFFF, 1'b1);
        // all-zero byte ended by the stop edge, across the timestamp wrap
        t = 32'hFFFF_F800;
        queue_frame(8'h00, t, p, 0, 1'b0, 10);
        // all-ones byte: early poll does nothing, late poll times out
        t = t + 20 * p;
        queue_frame(8'hFF, t, p, 0, 1'b0, 10);
        queue_event(KIND_POLL, t + 3 * p, 1'b0);
        queue_event(KIND_POLL, t + 9 * p + 1, 1'b1);
        // glitches shorter than half a bit inside a frame
        t = t + 20 * p;
        queue_event(KIND_EDGE, t, 1'b0);
        queue_event(KIND_EDGE, t + 100, 1'b1);
        queue_event(KIND_EDGE, t + 200, 1'b0);
        queue_frame(8'h0F, t, p, 0, 1'b1, 10);
        // long interval: frame padded out and a new start bit on the same edge
        t = t + 20 * p;
        queue_frame(8'hFF, t, p, 0, 1'b0, 10);
        queue_frame(8'h0F, t + 13 * p, p, 0, 1'b0, 10);
        // timeout fills with a low last level
        t = t + 40 * p;
        queue_frame(8'h01, t, p, 0, 1'b0, 9);
        queue_event(KIND_POLL, t + 30 * p, 1'b0);
    endtask

    // Mostly clean frames with random content, some broken frames and noise
    task automatic queue_random(input logic [urxts_pkg::PERIOD_W-1:0] cfg_val, input int count);
        logic [31:0] per, t0;
        int          goal, r, k;
        per  = (cfg_val == '0) ? 32'd1 : {8'b0, cfg_val};
        t0   = $urandom;
        goal = events_queued + count;
        while (events_queued < goal) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                queue_frame(8'($urandom), t0, per, int'(per / 5), 1'b0, 10);
                if ($urandom_range(0, 1)) begin
                    queue_event(KIND_POLL, t0 + per * $urandom_range(9, 14)
                                + $urandom_range(0, per), 1'($urandom_range(0, 1)));
                    t0 = t0 + per * 16 + $urandom_range(0, 3 * per);
                end else begin
                    t0 = t0 + per * 10 + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3 * per));
                end
            end else if (r < 85) begin
                queue_frame(8'($urandom), t0, per, int'(per / 2), 1'b0, $urandom_range(1, 9));
                if ($urandom_range(0, 1))
                    queue_event(KIND_POLL, t0 + per * $urandom_range(2, 14),
                                1'($urandom_range(0, 1)));
                t0 = t0 + per * 16;
            end else begin
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++)
                    queue_event(1'($urandom_range(0, 1)),
                                ($urandom_range(0, 9) == 0) ? $urandom
                                                            : t0 + $urandom_range(0, 2 * per),
                                1'($urandom_range(0, 1)));
                t0 = t0 + per * 3;
            end
        end
    endtask

    // Sender holds until every transaction is in and every byte is out
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_events.size() != 0 || s_valid || bytes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_period(input logic [urxts_pkg::PERIOD_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    // Input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
                drv_item = pending_events.pop_front();
                s_valid      <= 1'b1;
                s_kind       <= drv_item.kind;
                s_timestamp  <= drv_item.ts;
                s_line_level <= drv_item.level;
                send_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: check results, then predict from the input transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            rx_bits    = '0;
            rx_shift   = '0;
            edge_stamp = '0;
            period_cfg = urxts_pkg::PERIOD_RESET;
        end else begin
            if (m_valid && m_ready) begin
                bytes_seen++;
                if (bytes_due.size() == 0) begin
                    $error("unexpected result: rx_byte %02h by_timeout %0b",
                           m_rx_byte, m_by_timeout);
                    errors++;
                end else begin
                    got_byte = bytes_due.pop_front();
                    if (m_rx_byte !== got_byte.data) begin
                        $error("rx_byte mismatch: expected %02h, actual %02h",
                               got_byte.data, m_rx_byte);
                        errors++;
                    end
                    if (m_by_timeout !== got_byte.by_tout) begin
                        $error("by_timeout mismatch: expected %0b, actual %0b",
                               got_byte.by_tout, m_by_timeout);
                        errors++;
                    end
                end
                // long receiver stall so the block backs up into its input
                if (bytes_seen == 150 || bytes_seen == 700) rx_hold = RX_STALL_CYCLES;
            end
            if (cfg_wr_en) period_cfg = cfg_wr_data;
            if (s_valid && s_ready)
                predict_rx('{kind: s_kind, ts: s_timestamp, level: s_line_level});
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                rx_hold = pick_gap();
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Test sequence
    initial begin
        logic [urxts_pkg::PERIOD_W-1:0] periods[8];
        periods[0] = 24'd1;
        periods[1] = 24'hFF_FFFF;
        periods[2] = 24'($urandom_range(2, 40));
        periods[3] = 24'd0;
        periods[4] = 24'($urandom_range(300, 3000));
        periods[5] = 24'($urandom_range(50000, 24'hFF_FFFF));
        periods[6] = 24'($urandom_range(41, 299));
        periods[7] = urxts_pkg::PERIOD_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        queue_directed();
        wait_drained();
        for (int ph = 0; ph < 8; ph++) begin
            no_idle = (ph % 3 == 2);
            write_period(periods[ph]);
            queue_random(periods[ph], PHASE_ITEMS);
            wait_drained();
        end
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
